FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define PBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/pbs_pkg.sv
// shared types and constants of the permutation enumerator
// no dependencies
package pbs_pkg;

    localparam int VAL_W = 8;
    localparam int POS_W = 3;

    typedef struct packed {
        logic                    command;
        logic signed [VAL_W-1:0] element_value;
        logic                    last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] perm_value;
        logic [POS_W-1:0]        position;
        logic                    last_of_perm;
        logic                    exhausted;
    } t_out_item;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SW_RA,
        S_SW_RB,
        S_SW_WA,
        S_SW_WB,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT,
        S_EXH
    } t_state;

    typedef struct packed {
        logic load;
        logic first_descend;
        logic walk_init;
        logic rd_a;
        logic rd_b;
        logic wr_a;
        logic wr_b;
        logic inc_idx;
        logic dec_lvl;
        logic set_done;
        logic descend;
        logic emit_start;
        logic emit_step;
        logic emit_exh;
    } t_dp_cmd;

    typedef struct packed {
        logic set_empty;
        logic done;
        logic started;
        logic can_inc;
        logic lvl_zero;
        logic emit_last;
    } t_dp_status;

endpackage

FILE: rtl/core/pbs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/pbs_ctrl.sv
// controller state machine of the permutation enumerator
// depends on pbs_pkg
module pbs_ctrl import pbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       i_command,
    input  t_dp_status i_status,
    output logic       busy,
    output logic       o_strobe,
    output t_dp_cmd    o_cmd
);
    t_state r_state, n_state;
    logic   r_redo, n_redo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_redo  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_redo  <= n_redo;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_redo  = r_redo;
        case (r_state)
            S_IDLE: begin
                if (start && (i_command == CMD_ADVANCE)) begin
                    if (i_status.set_empty || i_status.done) begin
                        n_state = S_EXH;
                    end else if (!i_status.started) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_SW_RA;
                        n_redo  = 1'b0;
                    end
                end
            end
            S_SW_RA: n_state = S_SW_RB;
            S_SW_RB: n_state = S_SW_WA;
            S_SW_WA: n_state = S_SW_WB;
            S_SW_WB: begin
                n_state = r_redo ? S_EMIT_RD : S_CHECK;
            end
            S_CHECK: begin
                if (i_status.can_inc) begin
                    n_state = S_SW_RA;
                    n_redo  = 1'b1;
                end else if (i_status.lvl_zero) begin
                    n_state = S_EXH;
                end else begin
                    n_state = S_SW_RA;
                    n_redo  = 1'b0;
                end
            end
            S_EMIT_RD: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EXH:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd    = '0;
        busy     = 1'b1;
        o_strobe = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (!i_status.set_empty && !i_status.done) begin
                        if (!i_status.started) begin
                            o_cmd.first_descend = 1'b1;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                        end
                    end
                end
            end
            S_SW_RA: o_cmd.rd_a = 1'b1;
            S_SW_RB: o_cmd.rd_b = 1'b1;
            S_SW_WA: o_cmd.wr_a = 1'b1;
            S_SW_WB: begin
                o_cmd.wr_b    = 1'b1;
                o_cmd.descend = r_redo;
            end
            S_CHECK: begin
                if (i_status.can_inc) begin
                    o_cmd.inc_idx = 1'b1;
                end else if (i_status.lvl_zero) begin
                    o_cmd.set_done = 1'b1;
                end else begin
                    o_cmd.dec_lvl = 1'b1;
                end
            end
            S_EMIT_RD: o_cmd.emit_start = 1'b1;
            S_EMIT: begin
                o_strobe        = 1'b1;
                o_cmd.emit_step = 1'b1;
            end
            S_EXH: begin
                o_strobe       = 1'b1;
                o_cmd.emit_exh = 1'b1;
            end
            default: busy = 1'b1;
        endcase
    end
endmodule

FILE: rtl/core/pbs_dp.sv
// datapath: working array ram, loop index stack, level and counters
// depends on pbs_pkg and pbs_ram
module pbs_dp import pbs_pkg::*; #(
    parameter int MAX_N = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_item  o_result
);
    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW = $clog2(MAX_N + 1);

    logic [CW-1:0] r_set_size, n_set_size;
    logic [CW-1:0] r_load_ptr, n_load_ptr;
    logic          r_started, n_started;
    logic          r_done, n_done;
    logic [AW-1:0] r_stack [MAX_N];
    logic [AW-1:0] n_stack [MAX_N];
    logic [AW-1:0] r_lvl, n_lvl;
    logic [AW-1:0] r_k, n_k;
    logic [VAL_W-1:0] r_va, n_va;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [VAL_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;

    logic [AW-1:0] idx_cur;
    logic          ptr_has_room;
    logic [CW-1:0] ptr_inc;
    logic          emit_last;

    assign idx_cur      = r_stack[r_lvl];
    assign ptr_has_room = r_load_ptr < CW'(MAX_N);
    assign ptr_inc      = r_load_ptr + CW'(ptr_has_room);
    assign emit_last    = (CW'(r_k) + CW'(1)) == r_set_size;

    always_comb begin
        n_set_size = r_set_size;
        n_load_ptr = r_load_ptr;
        n_started  = r_started;
        n_done     = r_done;
        n_stack    = r_stack;
        n_lvl      = r_lvl;
        n_k        = r_k;
        n_va       = r_va;
        if (i_cmd.load) begin
            if (i_item.last_element) begin
                n_set_size = ptr_inc;
                n_load_ptr = '0;
                n_started  = 1'b0;
                n_done     = 1'b0;
                n_lvl      = '0;
                for (int i = 0; i < MAX_N; i++) begin
                    n_stack[i] = '0;
                end
            end else begin
                n_load_ptr = ptr_inc;
            end
        end
        if (i_cmd.first_descend) begin
            n_started = 1'b1;
            for (int i = 0; i < MAX_N; i++) begin
                n_stack[i] = AW'(i);
            end
        end
        if (i_cmd.walk_init) begin
            n_lvl = AW'(r_set_size - CW'(1));
        end
        if (i_cmd.inc_idx) begin
            n_stack[r_lvl] = idx_cur + AW'(1);
        end
        if (i_cmd.dec_lvl) begin
            n_lvl = r_lvl - AW'(1);
        end
        if (i_cmd.set_done) begin
            n_done = 1'b1;
        end
        // levels below the one just advanced restart at identity swaps
        if (i_cmd.descend) begin
            for (int i = 0; i < MAX_N; i++) begin
                if (AW'(i) > r_lvl) begin
                    n_stack[i] = AW'(i);
                end
            end
        end
        if (i_cmd.rd_b) begin
            n_va = ram_rdata;
        end
        if (i_cmd.emit_start) begin
            n_k = '0;
        end else if (i_cmd.emit_step) begin
            n_k = r_k + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size <= '0;
            r_load_ptr <= '0;
            r_started  <= 1'b0;
            r_done     <= 1'b0;
            r_lvl      <= '0;
            r_k        <= '0;
            for (int i = 0; i < MAX_N; i++) begin
                r_stack[i] <= '0;
            end
        end else begin
            r_set_size <= n_set_size;
            r_load_ptr <= n_load_ptr;
            r_started  <= n_started;
            r_done     <= n_done;
            r_lvl      <= n_lvl;
            r_k        <= n_k;
            r_stack    <= n_stack;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va <= n_va;
    end

    // ram port selection
    always_comb begin
        ram_raddr = '0;
        if (i_cmd.rd_a) begin
            ram_raddr = idx_cur;
        end else if (i_cmd.rd_b) begin
            ram_raddr = r_lvl;
        end else if (i_cmd.emit_step) begin
            ram_raddr = r_k + AW'(1);
        end
    end

    always_comb begin
        ram_we    = (i_cmd.load && ptr_has_room) || i_cmd.wr_a || i_cmd.wr_b;
        ram_waddr = r_lvl;
        ram_wdata = r_va;
        if (i_cmd.load) begin
            ram_waddr = r_load_ptr[AW-1:0];
            ram_wdata = i_item.element_value;
        end else if (i_cmd.wr_a) begin
            ram_waddr = idx_cur;
            ram_wdata = ram_rdata;
        end
    end

    pbs_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_N)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        o_status.set_empty = (r_set_size == '0);
        o_status.done      = r_done;
        o_status.started   = r_started;
        o_status.can_inc   = (CW'(idx_cur) + CW'(1)) < r_set_size;
        o_status.lvl_zero  = (r_lvl == '0);
        o_status.emit_last = emit_last;
    end

    always_comb begin
        if (i_cmd.emit_exh) begin
            o_result.perm_value   = '0;
            o_result.position     = '0;
            o_result.last_of_perm = 1'b1;
            o_result.exhausted    = 1'b1;
        end else begin
            o_result.perm_value   = ram_rdata;
            o_result.position     = POS_W'(r_k);
            o_result.last_of_perm = emit_last;
            o_result.exhausted    = 1'b0;
        end
    end
endmodule

FILE: rtl/core/permutation_by_swap_backtrack_core.sv
// top level of the swap-backtracking permutation enumerator
// depends on pbs_pkg, pbs_ctrl, pbs_dp (which holds pbs_ram)
//
// usage
//   an input item is taken at a clock edge where start is high and busy low.
//   command load (0) writes element_value into the next free slot (dropped
//   once MAX_N slots are full); last_element closes the set and restarts the
//   enumeration. busy stays low through a load.
//   command advance (1) yields the next permutation in swap-backtracking
//   order as n result items, position 0 first, last_of_perm on the final
//   one; once all n! are out (or no set is loaded) it yields one item with
//   exhausted and last_of_perm set.
//   each result sits on o_result for one cycle with o_strobe high; results
//   cannot be stalled, the receiver must take them as they come.
// walk
//   first advance after a set is closed: no walk, only the result burst.
//   later advances: the walk pops through stack levels (1..n), then one more
//   swap and the result burst follow; the final walk that finds no more
//   permutations yields the exhausted item. each level costs a check state
//   plus a swap of two array slots through the ram's single read port.
// reset
//   synchronous, active low: set size, load pointer, loop stack and flags
//   clear; the working array itself is not cleared.
module permutation_by_swap_backtrack_core import pbs_pkg::*; #(
    parameter int MAX_N = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // controller sequences loads, stack walks, swaps and the result burst
    pbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_command(i_item.command),
        .i_status (dp_status),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (dp_cmd)
    );

    // datapath holds the working array, loop index stack and counters
    pbs_dp #(
        .MAX_N(MAX_N)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (dp_cmd),
        .o_status(dp_status),
        .o_result(o_result)
    );
endmodule

FILE: rtl/core/pbs_checker.sv
// port-level checks of the permutation enumerator, bound to the top level
// depends on pbs_pkg and assert_macros.svh
`include "assert_macros.svh"

module pbs_checker import pbs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_in_item  i_item,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);
    logic adv_taken;
    logic load_taken;
    logic exh_zeroed;

    assign adv_taken  = start && !busy && (i_item.command == CMD_ADVANCE);
    assign load_taken = start && !busy && (i_item.command == CMD_LOAD);
    assign exh_zeroed = o_result.last_of_perm && (o_result.position == '0)
                        && (o_result.perm_value == '0);

    // results only come out while an advance is being served
    `PBS_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)
    // an exhausted item is a single, zeroed, final item
    `PBS_ASSERT_IMP(a_exh_form, i_clk, i_rst_n, o_strobe && o_result.exhausted, exh_zeroed)
    // an accepted advance always keeps the block busy next cycle
    `PBS_ASSERT_NXT(a_adv_busy, i_clk, i_rst_n, adv_taken, busy)
    // a load completes at once and produces no item
    `PBS_ASSERT_NXT(a_load_quiet, i_clk, i_rst_n, load_taken, !busy && !o_strobe)
endmodule

bind permutation_by_swap_backtrack_core pbs_checker u_pbs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_item  (i_item),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

FILE: verif/permutation_by_swap_backtrack_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the swap-backtracking permutation enumerator
// depends on pbs_pkg and permutation_by_swap_backtrack_core
module permutation_by_swap_backtrack_core_tb;
    import pbs_pkg::*;

    localparam int SLOT_CNT = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_item = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    permutation_by_swap_backtrack_core #(
        .MAX_N(SLOT_CNT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // shadow copy of the enumerator state
    logic signed [VAL_W-1:0] work_arr [SLOT_CNT];
    logic [POS_W-1:0]        idx_stack [SLOT_CNT];
    int unsigned             set_n = 0;
    int unsigned             load_ptr = 0;
    bit                      perm_started = 1'b0;
    bit                      perm_done = 1'b0;

    t_out_item pending_elements [$];
    t_out_item next_element;
    int        mismatch_count = 0;
    int        sender_idle_pct = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void exchange_slots(input int unsigned a, input int unsigned b);
        logic signed [VAL_W-1:0] tmp;
        tmp         = work_arr[a];
        work_arr[a] = work_arr[b];
        work_arr[b] = tmp;
    endfunction

    function automatic void queue_exhausted();
        t_out_item r;
        r = '0;
        r.last_of_perm = 1'b1;
        r.exhausted    = 1'b1;
        pending_elements = {pending_elements, r};
    endfunction

    function automatic void queue_permutation(input int unsigned n);
        t_out_item r;
        for (int k = 0; k < n; k++) begin
            r.perm_value   = work_arr[k];
            r.position     = POS_W'(k);
            r.last_of_perm = (k == n - 1);
            r.exhausted    = 1'b0;
            pending_elements = {pending_elements, r};
        end
    endfunction

    // advances the shadow state by one accepted item and queues its elements
    function automatic void predict_enumerator(input t_in_item it);
        int unsigned n;
        int unsigned lvl;
        int unsigned idx;
        bit          found;
        n = set_n;
        if (it.command == CMD_LOAD) begin
            if (load_ptr < SLOT_CNT) begin
                work_arr[load_ptr] = it.element_value;
                load_ptr++;
            end
            if (it.last_element) begin
                set_n    = load_ptr;
                load_ptr = 0;
                foreach (idx_stack[k]) idx_stack[k] = '0;
                perm_started = 1'b0;
                perm_done    = 1'b0;
            end
            return;
        end
        if (n == 0 || perm_done) begin
            queue_exhausted();
            return;
        end
        if (!perm_started) begin
            perm_started = 1'b1;
            for (int l = 0; l < n; l++) idx_stack[l] = POS_W'(l);
            queue_permutation(n);
            return;
        end
        // pop levels, undoing each swap, until one can move to its next slot
        found = 1'b0;
        lvl   = n;
        while (lvl > 0 && !found) begin
            lvl--;
            idx = idx_stack[lvl];
            exchange_slots(idx, lvl);
            if (idx + 1 < n) begin
                idx++;
                idx_stack[lvl] = POS_W'(idx);
                exchange_slots(idx, lvl);
                for (int l = lvl + 1; l < n; l++) idx_stack[l] = POS_W'(l);
                found = 1'b1;
            end
        end
        if (found) begin
            queue_permutation(n);
        end else begin
            perm_done = 1'b1;
            queue_exhausted();
        end
    endfunction

    // results cannot be held off, so every strobe is taken as it comes
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_elements.size() == 0) begin
                report_mismatch("element with nothing expected");
            end else begin
                next_element = pending_elements.pop_front();
                if (o_result.perm_value !== next_element.perm_value)
                    report_mismatch($sformatf("perm_value %0d, expected %0d",
                        o_result.perm_value, next_element.perm_value));
                if (o_result.position !== next_element.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                        o_result.position, next_element.position));
                if (o_result.last_of_perm !== next_element.last_of_perm)
                    report_mismatch($sformatf("last_of_perm %b, expected %b",
                        o_result.last_of_perm, next_element.last_of_perm));
                if (o_result.exhausted !== next_element.exhausted)
                    report_mismatch($sformatf("exhausted %b, expected %b",
                        o_result.exhausted, next_element.exhausted));
            end
        end
    end

    function automatic t_in_item make_item(input logic cmd, input logic [VAL_W-1:0] val,
                                           input logic last);
        t_in_item it;
        it.command       = cmd;
        it.element_value = val;
        it.last_element  = last;
        return it;
    endfunction

    // drive at the falling edge, take the item at the first rising edge with busy low
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict_enumerator(it);
    endtask

    task automatic send_advance();
        send_item(make_item(CMD_ADVANCE, VAL_W'($urandom), 1'($urandom)));
    endtask

    task automatic send_set(input int unsigned n_loads);
        for (int k = 0; k < n_loads; k++)
            send_item(make_item(CMD_LOAD, VAL_W'($urandom), k == n_loads - 1));
    endtask

    // after the queue empties, wait out the longest walk with some margin
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_elements.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic test_empty_advance();
        send_item(make_item(CMD_ADVANCE, 8'h00, 1'b0));
    endtask

    task automatic test_single_element();
        send_item(make_item(CMD_LOAD, 8'h80, 1'b1));
        send_item(make_item(CMD_ADVANCE, 8'hff, 1'b1));
        send_item(make_item(CMD_ADVANCE, 8'h00, 1'b0));
    endtask

    // all 6 orders of three extreme values, then exhausted twice
    task automatic test_value_extremes();
        send_item(make_item(CMD_LOAD, 8'h7f, 1'b0));
        send_item(make_item(CMD_LOAD, 8'h80, 1'b0));
        send_item(make_item(CMD_LOAD, 8'h00, 1'b1));
        repeat (8) send_advance();
    endtask

    // nine loads, the ninth carries last; its value is dropped but it closes the set
    task automatic test_load_overflow();
        send_set(9);
        repeat (2) send_advance();
    endtask

    task automatic test_random_traffic(input int pct, input int n_items);
        int          sent;
        int unsigned roll;
        int unsigned n;
        int unsigned n_loads;
        int unsigned n_adv;
        bit          paused;
        sent            = 0;
        paused          = 1'b0;
        sender_idle_pct = pct;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 6)
                n = 8;
            else if (roll < 20)
                n = 5;
            else
                n = $urandom_range(1, 4);
            n_loads = (n == 8) ? $urandom_range(8, 10) : n;
            send_set(n_loads);
            sent += n_loads;
            case (n)
                1: n_adv = $urandom_range(1, 3);
                2: n_adv = $urandom_range(1, 4);
                3: n_adv = $urandom_range(1, 8);
                4: n_adv = $urandom_range(1, 26);
                default: n_adv = $urandom_range(1, 12);
            endcase
            for (int k = 0; k < n_adv; k++) begin
                // now and then overwrite the array mid-walk
                if ($urandom_range(19) == 0)
                    send_item(make_item(CMD_LOAD, VAL_W'($urandom), 1'b0));
                else
                    send_advance();
            end
            sent += n_adv;
            if (!paused && sent >= n_items / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_advance();
        test_single_element();
        test_value_extremes();
        test_load_overflow();
        test_random_traffic(8, 90);
        test_random_traffic(85, 80);
        test_random_traffic(0, 80);
        wait_drained();
        if (mismatch_count == 0 && pending_elements.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
